// ----- design/crlf_sensor_reply_parser_unit_macros.svh -----
// Assertion macros shared by the reply parser modules
`ifndef CRLF_SENSOR_REPLY_PARSER_UNIT_MACROS_SVH
`define CRLF_SENSOR_REPLY_PARSER_UNIT_MACROS_SVH

// check cons in the same cycle as ante
`define CSRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define CSRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/csrp_pkg.sv -----
// Shared types and constants of the reply parser
package csrp_pkg;

  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_V     = 8'h56;
  localparam logic [7:0] CHR_EQ    = 8'h3D;
  localparam logic [7:0] CHR_O     = 8'h4F;
  localparam logic [7:0] CHR_K     = 8'h4B;

  localparam int TAG_LEN = 9;
  localparam logic [TAG_LEN-1:0][7:0] VERSION_TAG = {
    8'h3D, 8'h4E, 8'h4F, 8'h49, 8'h53, 8'h52, 8'h45, 8'h56, 8'h2B
  };

  localparam int VIEW_LEN = 12;
  localparam int MIN_INDEX = 3;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_VERSION = 3'd0;
  localparam kind_t KIND_VOLTAGE = 3'd1;
  localparam kind_t KIND_OK      = 3'd2;
  localparam kind_t KIND_UNKNOWN = 3'd3;
  localparam kind_t KIND_SHORT   = 3'd4;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] d_hi;
    logic [7:0] d_mid;
    logic [7:0] d_lo;
  } line_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ----- design/crlf_sensor_reply_parser_unit.sv -----
// A line result passes the queue, then the result register, to the out_ ports.
// Throughput: one byte per cycle unless in_full; classification queue and result
// register hold up to 3 results; in_full rises only when all wait on out_pop.
// Reset: synchronous, active low; clears previous byte, write index, line
// store and queue, leaving no result pending.
// Top level of the CR/LF sensor reply parser
module crlf_sensor_reply_parser_unit #(
  parameter int LINE_DEPTH = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [2:0]  out_line_kind,
  output logic [15:0] out_reply_value
);
  import csrp_pkg::*;

  logic        acc;
  logic        rec_push;
  line_rec_t   wr_rec;
  line_rec_t   rd_rec;
  queue_stat_t q_stat;
  logic        q_pop;

  assign in_full = q_stat.full;
  assign acc     = in_push && !q_stat.full;

  csrp_front #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .rx_byte (in_rx_byte),
    .rec_push(rec_push),
    .rec     (wr_rec)
  );

  csrp_queue #(
    .DEPTH(2)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rec_push),
    .wr_rec(wr_rec),
    .pop   (q_pop),
    .rd_rec(rd_rec),
    .stat  (q_stat)
  );

  csrp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_rec          (rd_rec),
    .q_pop          (q_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_line_kind  (out_line_kind),
    .out_reply_value(out_reply_value)
  );

endmodule

// ----- design/csrp_front.sv -----
// Front end: line store, CR/LF detection and line classification
module csrp_front #(
  parameter int LINE_DEPTH = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic [7:0]         rx_byte,
  output logic               rec_push,
  output csrp_pkg::line_rec_t rec
);
  import csrp_pkg::*;

  localparam int IDX_W = $clog2(LINE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_DEPTH - 1);

  logic [7:0]       prev_r, prev_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       store_r [LINE_DEPTH];
  logic [7:0]       view [VIEW_LEN];
  logic [IDX_W:0]   idx_inc;
  logic             line_end;
  logic             tag_ok;
  logic             volt_ok;
  logic             ok_ok;

  assign line_end = (prev_r == CHR_CR) && (rx_byte == CHR_LF);
  assign idx_inc  = {1'b0, idx_r} + (IDX_W+1)'(1);
  assign rec_push = acc && line_end;

  always_comb begin
    for (int i = 0; i < VIEW_LEN; i++) begin
      if (idx_r == IDX_W'(i)) begin
        view[i] = CHR_LF;
      end else if (idx_inc == (IDX_W+1)'(i)) begin
        view[i] = CHR_NUL;
      end else begin
        view[i] = store_r[i];
      end
    end
  end

  always_comb begin
    tag_ok = 1'b1;
    for (int i = 0; i < TAG_LEN; i++) begin
      if (view[i] != VERSION_TAG[i]) begin
        tag_ok = 1'b0;
      end
    end
    volt_ok = (view[0] == CHR_PLUS) && (view[1] == CHR_V) && (view[2] == CHR_EQ);
    ok_ok   = (view[0] == CHR_O) && (view[1] == CHR_K);
  end

  always_comb begin
    if (idx_r < IDX_W'(MIN_INDEX)) begin
      rec.kind = KIND_SHORT;
    end else if (tag_ok) begin
      rec.kind = KIND_VERSION;
    end else if (volt_ok) begin
      rec.kind = KIND_VOLTAGE;
    end else if (ok_ok) begin
      rec.kind = KIND_OK;
    end else begin
      rec.kind = KIND_UNKNOWN;
    end
    rec.d_hi  = tag_ok ? view[9] : view[3];
    rec.d_mid = tag_ok ? view[11] : view[5];
    rec.d_lo  = view[6];
  end

  always_comb begin
    idx_nxt  = idx_r;
    prev_nxt = prev_r;
    if (acc) begin
      if (line_end) begin
        idx_nxt  = '0;
        prev_nxt = CHR_NUL;
      end else begin
        idx_nxt  = (idx_r == LAST_IDX) ? '0 : idx_r + IDX_W'(1);
        prev_nxt = rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      idx_r  <= '0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      prev_r <= prev_nxt;
      idx_r  <= idx_nxt;
      for (int i = 0; i < LINE_DEPTH; i++) begin
        if (acc && (idx_r == IDX_W'(i))) begin
          store_r[i] <= rx_byte;
        end else if (acc && line_end && (idx_inc == (IDX_W+1)'(i))) begin
          store_r[i] <= CHR_NUL;
        end
      end
    end
  end

  `include "crlf_sensor_reply_parser_unit_macros.svh"

  `CSRP_ASSERT_NEXT(a_idx_cleared, rec_push, (idx_r == '0) && (prev_r == CHR_NUL), "index not cleared after line end")
  `CSRP_ASSERT_NOW(a_idx_range, 1'b1, idx_r <= LAST_IDX, "write index out of range")

endmodule

// ----- design/csrp_queue.sv -----
// Short queue of classified lines between front and back end
module csrp_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  csrp_pkg::line_rec_t   wr_rec,
  input  logic                  pop,
  output csrp_pkg::line_rec_t   rd_rec,
  output csrp_pkg::queue_stat_t stat
);
  import csrp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  line_rec_t        slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_rec     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `include "crlf_sensor_reply_parser_unit_macros.svh"

  `CSRP_ASSERT_NOW(a_no_push_full, push, !stat.full, "push into full queue")
  `CSRP_ASSERT_NOW(a_count_range, 1'b1, count_r <= CNT_W'(DEPTH), "queue count overflow")

endmodule

// ----- design/csrp_back.sv -----
// Back end: value decode and result register
module csrp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  csrp_pkg::queue_stat_t q_stat,
  input  csrp_pkg::line_rec_t   q_rec,
  output logic                  q_pop,
  input  logic                  out_pop,
  output logic                  out_empty,
  output logic [2:0]            out_line_kind,
  output logic [15:0]           out_reply_value
);
  import csrp_pkg::*;

  logic        valid_r, valid_nxt;
  kind_t       kind_r;
  logic [15:0] value_r;
  logic [15:0] hi_term;
  logic [15:0] mid_term;
  logic [15:0] lo_term;
  logic [15:0] value_calc;

  assign q_pop     = !q_stat.empty && (!valid_r || out_pop);
  assign valid_nxt = q_pop || (valid_r && !out_pop);

  always_comb begin
    hi_term  = 16'(({8'h00, q_rec.d_hi} - {8'h00, CHR_ZERO}) * 16'd100);
    mid_term = 16'(({8'h00, q_rec.d_mid} - {8'h00, CHR_ZERO}) * 16'd10);
    lo_term  = {8'h00, q_rec.d_lo} - {8'h00, CHR_ZERO};
    case (q_rec.kind)
      KIND_VERSION: value_calc = hi_term + mid_term;
      KIND_VOLTAGE: value_calc = hi_term + mid_term + lo_term;
      default:      value_calc = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r  <= q_rec.kind;
      value_r <= value_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_empty       = !valid_r;
  assign out_line_kind   = kind_r;
  assign out_reply_value = value_r;

  `include "crlf_sensor_reply_parser_unit_macros.svh"

  `CSRP_ASSERT_NOW(a_zero_value, valid_r && (kind_r != KIND_VERSION) && (kind_r != KIND_VOLTAGE), value_r == '0, "non-zero value for non-numeric line")

endmodule
